### rtl/pad_pkg.sv
// Package for point_at_distance_along_line: widths, constants and the
// sideband structs that travel beside the root and divider pipelines.
// No dependencies.
`default_nettype none
package pad_pkg;
  localparam int FRAC_BITS  = 8;
  localparam int SQRT_EXT   = 7;
  localparam int CW         = 24;             // input coordinate width
  localparam int LW         = 23;             // length width
  localparam int DW         = CW + 1;         // difference width
  localparam int MW         = DW + LW;        // |d| * length width
  localparam int SW         = 2 * DW;         // sum of squares width
  localparam int RADW       = 64;             // radicand width
  localparam int ROOTW      = RADW / 2;       // root width
  localparam int NUMW       = MW + SQRT_EXT;  // numerator width
  localparam int QW         = LW;             // quotient width
  localparam int OW         = 16;             // output coordinate width

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic                 sgx;
    logic                 sgy;
    logic                 degen;
  } pad_dv_sb_t;

  typedef struct packed {
    pad_dv_sb_t     base;
    logic [MW-1:0]  nx;
    logic [MW-1:0]  ny;
  } pad_sq_sb_t;
endpackage
`default_nettype wire

### rtl/pad_sqrt.sv
// Pipelined integer square root, one root bit per stage (ROOTW stages).
// Depends on pad_pkg.
`default_nettype none
module pad_sqrt (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [pad_pkg::RADW-1:0] in_rad,
  input  wire pad_pkg::pad_sq_sb_t      in_sb,
  output logic                          out_valid,
  output logic [pad_pkg::ROOTW-1:0]     out_root,
  output pad_pkg::pad_sq_sb_t           out_sb
);
  import pad_pkg::*;

  logic                 vld  [0:ROOTW];
  logic [RADW-1:0]      rad  [0:ROOTW];
  logic [ROOTW+1:0]     rem  [0:ROOTW];
  logic [ROOTW-1:0]     root [0:ROOTW];
  pad_sq_sb_t           sb   [0:ROOTW];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sb[0]   = in_sb;

  for (genvar k = 0; k < ROOTW; k++) begin : g_stage
    logic [ROOTW+3:0] cur;
    logic [ROOTW+3:0] trial;
    logic             take;
    assign cur   = {rem[k], rad[k][RADW-1 -: 2]};
    assign trial = {2'b00, root[k], 2'b01};
    assign take  = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rad[k+1]  <= {rad[k][RADW-3:0], 2'b00};
        rem[k+1]  <= take ? (ROOTW+2)'(cur - trial) : (ROOTW+2)'(cur);
        root[k+1] <= {root[k][ROOTW-2:0], take};
        sb[k+1]   <= sb[k];
      end
    end
  end

  assign out_valid = vld[ROOTW];
  assign out_root  = root[ROOTW];
  assign out_sb    = sb[ROOTW];
endmodule
`default_nettype wire

### rtl/pad_div.sv
// Pipelined two-lane restoring divider sharing one divisor, one quotient
// bit per stage (QW stages). Depends on pad_pkg.
`default_nettype none
module pad_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [pad_pkg::MW-1:0]   in_nx,
  input  wire logic [pad_pkg::MW-1:0]   in_ny,
  input  wire logic [pad_pkg::ROOTW-1:0] in_den,
  input  wire pad_pkg::pad_dv_sb_t      in_sb,
  output logic                          out_valid,
  output logic [pad_pkg::QW-1:0]        out_qx,
  output logic [pad_pkg::QW-1:0]        out_qy,
  output pad_pkg::pad_dv_sb_t           out_sb
);
  import pad_pkg::*;

  localparam int LOW = NUMW - ROOTW;   // numerator bits fed one per stage

  logic              vld [0:QW];
  logic [ROOTW-1:0]  den [0:QW];
  logic [ROOTW-1:0]  rx  [0:QW];
  logic [ROOTW-1:0]  ry  [0:QW];
  logic [LOW-1:0]    lx  [0:QW];
  logic [LOW-1:0]    ly  [0:QW];
  logic [QW-1:0]     qx  [0:QW];
  logic [QW-1:0]     qy  [0:QW];
  pad_dv_sb_t        sb  [0:QW];

  logic [NUMW-1:0] numx, numy;
  assign numx = {in_nx, {SQRT_EXT{1'b0}}};
  assign numy = {in_ny, {SQRT_EXT{1'b0}}};

  assign vld[0] = in_valid;
  assign den[0] = in_den;
  assign rx[0]  = numx[NUMW-1 -: ROOTW];
  assign ry[0]  = numy[NUMW-1 -: ROOTW];
  assign lx[0]  = numx[LOW-1:0];
  assign ly[0]  = numy[LOW-1:0];
  assign qx[0]  = '0;
  assign qy[0]  = '0;
  assign sb[0]  = in_sb;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [ROOTW:0] cx, cy, dd;
    logic           tx, ty;
    assign cx = {rx[k], lx[k][LOW-1]};
    assign cy = {ry[k], ly[k][LOW-1]};
    assign dd = {1'b0, den[k]};
    assign tx = cx >= dd;
    assign ty = cy >= dd;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        den[k+1] <= den[k];
        rx[k+1]  <= tx ? ROOTW'(cx - dd) : ROOTW'(cx);
        ry[k+1]  <= ty ? ROOTW'(cy - dd) : ROOTW'(cy);
        lx[k+1]  <= {lx[k][LOW-2:0], 1'b0};
        ly[k+1]  <= {ly[k][LOW-2:0], 1'b0};
        qx[k+1]  <= {qx[k][QW-2:0], tx};
        qy[k+1]  <= {qy[k][QW-2:0], ty};
        sb[k+1]  <= sb[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_qx    = qx[QW];
  assign out_qy    = qy[QW];
  assign out_sb    = sb[QW];
endmodule
`default_nettype wire

### rtl/point_at_distance_along_line.sv
// Top level: point at a given distance from a start point towards a target.
// Depends on pad_pkg, pad_sqrt and pad_div.
//
//  channel   | tdata (lowest bit up)                          | tuser      | dir
//  s_axis    | start_x, start_y, target_x, target_y, length   | -          | in
//  m_axis    | result_x, result_y                             | degenerate | out
//
// One item per cycle while m_axis does not stall. Stages in order: difference,
// squares and products, sum, 32 root stages (one bit each), 23 divider stages
// (one quotient bit each), offset add, pixel conversion into the output register.
// Reset clears every stage valid bit; payload registers are not reset.
// A stall on m_axis freezes the whole pipeline; s_axis_tready follows.
`default_nettype none
module point_at_distance_along_line (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [119:0] s_axis_tdata,  // start_x, start_y, target_x, target_y,
                                           // desired_length, zero pad
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // result_x, result_y
  output logic              m_axis_tuser   // degenerate
);
  import pad_pkg::*;

  logic en;
  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  // unpack
  logic signed [CW-1:0] in_sx, in_sy, in_tx, in_ty;
  logic [LW-1:0]        in_len;
  assign in_sx  = s_axis_tdata[CW-1:0];
  assign in_sy  = s_axis_tdata[2*CW-1:CW];
  assign in_tx  = s_axis_tdata[3*CW-1:2*CW];
  assign in_ty  = s_axis_tdata[4*CW-1:3*CW];
  assign in_len = s_axis_tdata[4*CW+LW-1:4*CW];

  // stage 1: differences
  logic                 v1;
  logic signed [DW-1:0] dx1, dy1;
  logic signed [CW-1:0] sx1, sy1;
  logic [LW-1:0]        len1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
    if (en) begin
      dx1  <= DW'(in_tx) - DW'(in_sx);
      dy1  <= DW'(in_ty) - DW'(in_sy);
      sx1  <= in_sx;
      sy1  <= in_sy;
      len1 <= in_len;
    end
  end

  // stage 2: squares and length products on magnitudes
  logic [DW-1:0] ax1, ay1;
  assign ax1 = dx1[DW-1] ? DW'(-dx1) : DW'(dx1);
  assign ay1 = dy1[DW-1] ? DW'(-dy1) : DW'(dy1);

  logic           v2;
  logic [SW-1:0]  qx2, qy2;
  pad_sq_sb_t     sb2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      qx2            <= ax1 * ax1;
      qy2            <= ay1 * ay1;
      sb2.nx         <= ax1 * len1;
      sb2.ny         <= ay1 * len1;
      sb2.base.sx    <= sx1;
      sb2.base.sy    <= sy1;
      sb2.base.sgx   <= dx1[DW-1];
      sb2.base.sgy   <= dy1[DW-1];
      sb2.base.degen <= (dx1 == '0) && (dy1 == '0);
    end
  end

  // stage 3: sum of squares, scaled for the extra root bits
  logic            v3;
  logic [RADW-1:0] rad3;
  pad_sq_sb_t      sb3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      rad3 <= RADW'({qx2 + qy2, {(2*SQRT_EXT){1'b0}}});
      sb3  <= sb2;
    end
  end

  // length of the direction vector
  logic             vr;
  logic [ROOTW-1:0] root;
  pad_sq_sb_t       sbr;
  pad_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .in_rad(rad3), .in_sb(sb3),
    .out_valid(vr), .out_root(root), .out_sb(sbr)
  );

  // offsets: |d| * length * 2^SQRT_EXT / root
  logic        vd;
  logic [QW-1:0] qx, qy;
  pad_dv_sb_t  sbd;
  pad_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vr), .in_nx(sbr.nx), .in_ny(sbr.ny), .in_den(root),
    .in_sb(sbr.base),
    .out_valid(vd), .out_qx(qx), .out_qy(qy), .out_sb(sbd)
  );

  // offset add; a degenerate item keeps the start point
  localparam int PW = CW + 2;
  logic [QW-1:0]        mqx, mqy;
  logic signed [PW-1:0] ox, oy;
  assign mqx = sbd.degen ? '0 : qx;
  assign mqy = sbd.degen ? '0 : qy;
  assign ox  = sbd.sgx ? -$signed(PW'(mqx)) : $signed(PW'(mqx));
  assign oy  = sbd.sgy ? -$signed(PW'(mqy)) : $signed(PW'(mqy));

  logic                 vp;
  logic signed [PW-1:0] px, py;
  logic                 degp;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= vd;
    end
    if (en) begin
      px   <= PW'(sbd.sx) + ox;
      py   <= PW'(sbd.sy) + oy;
      degp <= sbd.degen;
    end
  end

  // whole pixels, truncated toward zero, saturated
  function automatic logic [OW-1:0] to_pixel(input logic signed [PW-1:0] p);
    logic signed [PW:0] biased;
    logic signed [PW:0] q;
    logic [OW-1:0]      r;
    biased = p[PW-1] ? (PW+1)'(p) + (PW+1)'((1 << FRAC_BITS) - 1) : (PW+1)'(p);
    q      = biased >>> FRAC_BITS;
    if (q > (PW+1)'(32767))       r = 16'h7FFF;
    else if (q < -(PW+1)'(32768)) r = 16'h8000;
    else                          r = q[OW-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= vp;
    end
    if (en) begin
      m_axis_tdata <= {to_pixel(py), to_pixel(px)};
      m_axis_tuser <= degp;
    end
  end
endmodule
`default_nettype wire

### test/point_at_distance_along_line_tb.sv
// Testbench for point_at_distance_along_line: streams start/target/length items
// through the block and checks every result item against an in-bench predictor.
// Depends on pad_pkg and the point_at_distance_along_line RTL.
`default_nettype none
module point_at_distance_along_line_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pad_pkg::*;

  typedef struct packed {
    logic signed [OW-1:0] px;
    logic signed [OW-1:0] py;
    logic                 degen;
  } pixel_point_t;

  // Holds the expected pixel points in arrival order and checks results.
  class point_scoreboard;
    pixel_point_t expected_points[$];
    int           failures = 0;

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic signed [OW-1:0] whole_pixel(longint p);
      longint q;
      q = p / (longint'(1) << FRAC_BITS);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[OW-1:0];
    endfunction

    // Work out the point for one accepted item and queue it.
    function void note_item(logic [119:0] data);
      longint          sx, sy, tx, ty, len, dx, dy, ox, oy, r;
      longint unsigned sq;
      pixel_point_t    pt;
      sx  = longint'(signed'(data[23:0]));
      sy  = longint'(signed'(data[47:24]));
      tx  = longint'(signed'(data[71:48]));
      ty  = longint'(signed'(data[95:72]));
      len = longint'(data[118:96]);
      dx  = tx - sx;
      dy  = ty - sy;
      if (dx == 0 && dy == 0) begin
        pt.px    = whole_pixel(sx);
        pt.py    = whole_pixel(sy);
        pt.degen = 1'b1;
      end else begin
        sq = longint'(dx * dx) + longint'(dy * dy);
        r  = longint'(root_floor(sq << (2 * SQRT_EXT)));
        ox = (dx * len * (longint'(1) << SQRT_EXT)) / r;
        oy = (dy * len * (longint'(1) << SQRT_EXT)) / r;
        pt.px    = whole_pixel(sx + ox);
        pt.py    = whole_pixel(sy + oy);
        pt.degen = 1'b0;
      end
      expected_points.push_back(pt);
    endfunction

    function void check_result(logic [31:0] data, logic user);
      pixel_point_t pt;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d degenerate=%0b", $time,
                 signed'(data[15:0]), signed'(data[31:16]), user);
        failures++;
        return;
      end
      pt = expected_points.pop_front();
      if (data[15:0] !== pt.px) begin
        $display("%0t: result_x expected %0d actual %0d", $time, pt.px,
                 signed'(data[15:0]));
        failures++;
      end
      if (data[31:16] !== pt.py) begin
        $display("%0t: result_y expected %0d actual %0d", $time, pt.py,
                 signed'(data[31:16]));
        failures++;
      end
      if (user !== pt.degen) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, pt.degen, user);
        failures++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;
  logic         m_axis_tuser;

  point_scoreboard board = new();
  bit              idle_on = 1'b1;   // cleared for stretches of back-to-back traffic
  bit              hold_req = 1'b0;  // asks the receiver for one long hold-off

  always #5 clk = ~clk;

  point_at_distance_along_line dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // start_x, start_y, target_x, target_y, length
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // result_x, result_y
    .m_axis_tuser  (m_axis_tuser)    // degenerate
  );

  // Note accepted items and check accepted results on the same edge they move.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) board.note_item(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Receiver: stalls randomly while idle_on is set, plus one long hold-off on request.
  initial begin : receiver
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      stall = idle_on ? $urandom_range(0, 10) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = 300;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
        @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      // advance until a result has moved
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      m_axis_tready <= 1'b0;
    end
  end

  // Offer one item, after a random gap while idle_on is set; hold it until accepted.
  task automatic send_item(logic signed [23:0] sx, logic signed [23:0] sy,
                           logic signed [23:0] tx, logic signed [23:0] ty,
                           logic [22:0] len);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, len, ty, tx, sy, sx};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic signed [23:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 24'($urandom());
      1: return 24'(int'($urandom_range(0, 16000)) - 8000);
      2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return 24'(int'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  // Build one random item: most aim the target near the start so results stay
  // in range, some are coincident, the rest spread across the whole field.
  task automatic send_random();
    logic signed [23:0] sx, sy, tx, ty;
    logic [22:0]        len;
    int                 kind;
    sx   = pick_coord();
    sy   = pick_coord();
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      tx = sx + 24'(int'($urandom_range(0, 4000)) - 2000);
      ty = sy + 24'(int'($urandom_range(0, 4000)) - 2000);
    end else if (kind == 6) begin
      tx = sx;
      ty = sy;
    end else begin
      tx = pick_coord();
      ty = pick_coord();
    end
    case ($urandom_range(0, 5))
      0:       len = '0;
      1:       len = 23'h7FFFFF;
      2:       len = 23'($urandom());
      default: len = 23'($urandom_range(0, 200000));
    endcase
    send_item(sx, sy, tx, ty, len);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corner cases
    send_item(24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF);
    send_item(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 23'h7FFFFF);
    send_item(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 23'h000001);
    send_item(24'sd1000, 24'sd2000, 24'sd1000, 24'sd2000, 23'd5000);     // coincident
    send_item(-24'sd300, -24'sd255, -24'sd300, -24'sd255, 23'd0);       // coincident, negative
    send_item(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 23'h7FFFFF);
    send_item(-24'sd513, 24'sd770, 24'sd4000, 24'sd4000, 23'd0);        // zero length
    send_item(24'sd0, 24'sd0, 24'sd1, 24'sd0, 23'd256);                 // unit step x
    send_item(24'sd0, 24'sd0, 24'sd0, -24'sd1, 23'd256);                // unit step -y
    send_item(24'sd0, 24'sd0, 24'sd1, 24'sd1, 23'h7FFFFF);              // diagonal, huge
    send_item(24'sd0, 24'sd0, -24'sd3, 24'sd4, 23'd1280);               // 3-4-5
    send_item(-24'sd100, -24'sd100, -24'sd200, -24'sd100, 23'd100);     // toward zero
    send_item(24'sh7FFF00, 24'sd0, 24'sh7FFFFF, 24'sd0, 23'h7FFFFF);    // saturate +x
    send_item(24'sh800000, 24'sd0, 24'sh800001, 24'sd0, 23'd0);         // floor of range
    send_item(24'sd0, 24'sd0, 24'sd0, 24'sd0, 23'h7FFFFF);
    send_item(24'sd128, -24'sd128, 24'sd129, -24'sd129, 23'd1);
    send_item(24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555, 23'h555555);
    send_item(24'shAAAAAA, 24'sh555555, 24'sh555555, 24'shAAAAAA, 23'h2AAAAA);

    for (int i = 0; i < 1250; i++) begin
      idle_on = !((i >= 300 && i < 400) || (i >= 900 && i < 960));
      if (i == 500) hold_req = 1'b1;
      if (i == 700) begin
        // pause until the pipeline has drained
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (board.expected_points.size() != 0);
      end
      send_random();
    end
    s_axis_tvalid <= 1'b0;
    idle_on = 1'b1;

    do @(posedge clk); while (board.expected_points.size() != 0);
    repeat (80) @(posedge clk);
    if (board.failures == 0 && board.expected_points.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #3ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
